>>> rtl/fspa_pkg.sv
// ----------------------------------------------------------------------------
// fspa_pkg: shared types and constants for the fixed slot pool allocator.
// Holds the action and status codes and the fixed field widths of the ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fspa_pkg;

  localparam int ACTION_W    = 3;
  localparam int SLOT_IDX_W  = 8;
  localparam int DATA_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int FREE_SLOT_W = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR   = 3'd0,
    ACT_TAKE    = 3'd1,
    ACT_RELEASE = 3'd2,
    ACT_FILL    = 3'd3,
    ACT_READ    = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_TAKEN    = 2'd1,
    ST_RELEASED = 2'd2,
    ST_OUTSIDE  = 2'd3
  } status_t;

  // One accepted transaction as seen by the storage units.
  typedef struct packed {
    logic    en;
    action_t act;
    logic    in_range;
  } slot_req_t;

endpackage

`default_nettype wire

>>> rtl/fspa_word_mem.sv
// ----------------------------------------------------------------------------
// fspa_word_mem: slot word storage.
// A synchronous memory with a registered read port. A written flag per slot
// makes unwritten and cleared slots read as zero without a clearing sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fspa_word_mem #(
  parameter int SLOT_COUNT = 16,
  parameter int WORD_WIDTH = 32,
  parameter int IDX_W      = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire fspa_pkg::slot_req_t   req,
  input  wire logic [IDX_W-1:0]      idx,
  input  wire logic [WORD_WIDTH-1:0] wdata,
  output logic      [WORD_WIDTH-1:0] rdata
);
  import fspa_pkg::*;

  logic [WORD_WIDTH-1:0] mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] written_r;
  logic [SLOT_COUNT-1:0] written_nxt;
  logic [WORD_WIDTH-1:0] rword_r;
  logic                  rvalid_r;
  logic                  wr_en;
  logic                  rd_en;

  assign wr_en = req.en && req.in_range && (req.act == ACT_FILL);
  assign rd_en = req.en && req.in_range && (req.act == ACT_READ);

  always_comb begin
    written_nxt = written_r;
    if (req.en && (req.act == ACT_CLEAR)) begin
      written_nxt = '0;
    end else if (wr_en) begin
      written_nxt[idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else begin
      written_r <= written_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rword_r  <= mem[idx];
      rvalid_r <= written_r[idx];
    end
  end

  assign rdata = rvalid_r ? rword_r : '0;

endmodule

`default_nettype wire

>>> rtl/fspa_occ_map.sv
// ----------------------------------------------------------------------------
// fspa_occ_map: slot occupancy bitmap.
// Applies take, release and clear to the bitmap and finds the lowest free slot
// of the current bitmap with a priority encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fspa_occ_map #(
  parameter int SLOT_COUNT = 16,
  parameter int IDX_W      = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fspa_pkg::slot_req_t req,
  input  wire logic [IDX_W-1:0]    idx,
  output logic                     cur_bit,
  output logic      [IDX_W-1:0]    free_idx,
  output logic                     none_free
);
  import fspa_pkg::*;

  logic [SLOT_COUNT-1:0] occ_r;
  logic [SLOT_COUNT-1:0] occ_nxt;

  assign cur_bit = req.in_range ? occ_r[idx] : 1'b0;

  always_comb begin
    occ_nxt = occ_r;
    if (req.en) begin
      case (req.act)
        ACT_CLEAR: begin
          occ_nxt = '0;
        end
        ACT_TAKE: begin
          if (req.in_range) begin
            occ_nxt[idx] = 1'b1;
          end
        end
        ACT_RELEASE: begin
          if (req.in_range) begin
            occ_nxt[idx] = 1'b0;
          end
        end
        default: begin
          occ_nxt = occ_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_comb begin
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!occ_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign none_free = &occ_r;

endmodule

`default_nettype wire

>>> rtl/fixed_slot_pool_allocator_core.sv
// ----------------------------------------------------------------------------
// fixed_slot_pool_allocator_core: fixed slot pool with an occupancy bitmap.
// An accepted transaction is registered in the s1 stage, then in the output stage.
// Throughput: one transaction per cycle while the output is not stalled.
// Reset clears the bitmap and the written flags at once; no clearing pass.
// All slots read as free and zero after reset or a clear action.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fixed_slot_pool_allocator_core #(
  parameter int SLOT_COUNT = 16,
  parameter int WORD_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [fspa_pkg::ACTION_W-1:0]      in_action,
  input  wire logic [fspa_pkg::SLOT_IDX_W-1:0]    in_slot_index,
  input  wire logic [fspa_pkg::DATA_W-1:0]        in_write_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [fspa_pkg::STATUS_W-1:0]      out_status,
  output logic      [fspa_pkg::DATA_W-1:0]        out_read_data,
  output logic      [fspa_pkg::FREE_SLOT_W-1:0]   out_free_slot,
  output logic                                    out_none_free
);
  import fspa_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [SLOT_IDX_W:0] SLOT_LIMIT = (SLOT_IDX_W + 1)'(SLOT_COUNT);

  logic                  accept;
  logic                  s1_adv;
  logic                  in_range;
  logic [IDX_W-1:0]      idx;
  slot_req_t             req;
  logic                  cur_bit;
  logic [IDX_W-1:0]      free_idx;
  logic                  none_free;
  logic [WORD_WIDTH-1:0] mem_rdata;
  status_t               status_now;

  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  status_t               s1_status_r;
  logic                  s1_read_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  status_t               out_status_r;
  logic [DATA_W-1:0]     out_read_data_r;
  logic [FREE_SLOT_W-1:0] out_free_slot_r;
  logic                  out_none_free_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;

  assign in_range = {1'b0, in_slot_index} < SLOT_LIMIT;
  assign idx      = in_slot_index[IDX_W-1:0];

  assign req.en       = accept;
  assign req.act      = action_t'(in_action);
  assign req.in_range = in_range;

  fspa_occ_map #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_occ_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .idx       (idx),
    .cur_bit   (cur_bit),
    .free_idx  (free_idx),
    .none_free (none_free)
  );

  fspa_word_mem #(
    .SLOT_COUNT (SLOT_COUNT),
    .WORD_WIDTH (WORD_WIDTH),
    .IDX_W      (IDX_W)
  ) u_word_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .idx   (idx),
    .wdata (WORD_WIDTH'(in_write_data)),
    .rdata (mem_rdata)
  );

  always_comb begin
    status_now = ST_OK;
    unique case (in_action) inside
      ACT_CLEAR: begin
        status_now = ST_OK;
      end
      ACT_TAKE: begin
        if (!in_range) begin
          status_now = ST_OUTSIDE;
        end else if (cur_bit) begin
          status_now = ST_TAKEN;
        end
      end
      ACT_RELEASE: begin
        if (!in_range) begin
          status_now = ST_OUTSIDE;
        end else if (!cur_bit) begin
          status_now = ST_RELEASED;
        end
      end
      ACT_FILL, ACT_READ: begin
        if (!in_range) begin
          status_now = ST_OUTSIDE;
        end
      end
      default: begin
        status_now = ST_OK;
      end
    endcase
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= status_now;
      s1_read_r   <= (in_action == ACT_READ) && in_range;
    end
  end

  // The bitmap already holds this transaction's update, so the encoder
  // output gives the lowest free slot after the step.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r    <= s1_status_r;
      out_read_data_r <= s1_read_r ? DATA_W'(mem_rdata) : '0;
      out_free_slot_r <= none_free ? '0 : FREE_SLOT_W'(free_idx);
      out_none_free_r <= none_free;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_read_data = out_read_data_r;
  assign out_free_slot = out_free_slot_r;
  assign out_none_free = out_none_free_r;

endmodule

`default_nettype wire
